/* hw/rtl/tel_pkg.sv */
`default_nettype none

package tel_pkg;

  // Field widths of the stream items
  localparam int CoordW   = 16;
  localparam int FracBits = 16;
  localparam int OutW     = 32;
  localparam int StW      = 3;
  localparam int SpanW    = 15;
  localparam logic [SpanW-1:0] SpanReset = SpanW'(30);

  // Status codes
  localparam logic [StW-1:0] ST_OK         = 3'd0;
  localparam logic [StW-1:0] ST_VERT_SIDE  = 3'd1;
  localparam logic [StW-1:0] ST_HORZ_SIDE  = 3'd2;
  localparam logic [StW-1:0] ST_PARALLEL   = 3'd3;
  localparam logic [StW-1:0] ST_VERT_EULER = 3'd4;

  // Internal exact-arithmetic widths
  localparam int DiffW   = CoordW + 1;       // vertex differences
  localparam int SumW    = CoordW + 2;       // coordinate sums
  localparam int ProdW   = 2 * DiffW;        // difference products
  localparam int CrossW  = ProdW + 1;        // cross product
  localparam int DW      = CrossW + 1;       // twice the cross product
  localparam int SqW     = ProdW + 1;        // squared side lengths
  localparam int TW      = DiffW + SqW;      // difference times squared length
  localparam int NumW    = TW + 1;           // bisector numerators
  localparam int DaW     = DW + CoordW;      // d times a vertex coordinate
  localparam int CnW     = NumW + 1;         // circumcenter numerators
  localparam int DsumW   = DW + SumW;        // d times difference sums
  localparam int DsW     = NumW + 3;         // Euler direction components
  localparam int BpW     = DsW + SumW;       // direction times vertex sums
  localparam int BaseW   = BpW + 1;          // intercept numerator
  localparam int SpanMulW = SpanW + 3;       // three times the span, signed
  localparam int StepW   = DsW + SpanMulW;
  localparam int EndW    = BaseW + 1;        // end height numerators
  localparam int Den3W   = DsW + 2;

  localparam int DivLat   = OutW + 2;        // divider latency in cycles
  localparam int MidDepth = 4;
  localparam int OutDepth = 2;

  typedef struct packed {
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] by_coord;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] ax;
  } tri_t;

  typedef struct packed {
    logic [StW-1:0]          st;
    logic signed [SumW-1:0]  sx;
    logic signed [SumW-1:0]  sy;
    logic signed [CnW-1:0]   cnx;
    logic signed [CnW-1:0]   cny;
    logic signed [DW-1:0]    d;
    logic signed [DsW-1:0]   ds;
    logic signed [DsW-1:0]   ns;
  } mid_t;

  typedef struct packed {
    logic [StW-1:0]  status;
    logic [OutW-1:0] right_y;
    logic [OutW-1:0] left_y;
    logic [OutW-1:0] euler_intercept;
    logic [OutW-1:0] euler_slope;
    logic [OutW-1:0] circum_y;
    logic [OutW-1:0] circum_x;
    logic [OutW-1:0] centroid_y;
    logic [OutW-1:0] centroid_x;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/tel_queue.sv */
`default_nettype none

module tel_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  not_empty,
  output logic                  full
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [CntW-1:0]  count;

  assign not_empty = (count != '0);
  assign full      = (count == CntW'(DEPTH));
  assign rdata     = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tel_front.sv */
`default_nettype none

module tel_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire tel_pkg::tri_t   in_tri,
  output logic                 out_valid,
  output tel_pkg::mid_t        out_mid
);

  import tel_pkg::*;

  logic [5:0] vld;

  // stage 1: differences, sums, side classification
  logic signed [DiffW-1:0] bxr_c, byr_c, cxr_c, cyr_c;
  logic signed [CoordW-1:0] f1_ax, f1_ay;
  logic signed [DiffW-1:0] f1_bxr, f1_byr, f1_cxr, f1_cyr;
  logic signed [SumW-1:0]  f1_sbc, f1_sby, f1_sx, f1_sy;
  logic [StW-1:0]          f1_st;

  // stage 2: products of differences
  logic signed [CoordW-1:0] f2_ax, f2_ay;
  logic signed [DiffW-1:0] f2_bxr, f2_byr, f2_cxr, f2_cyr;
  logic signed [SumW-1:0]  f2_sbc, f2_sby, f2_sx, f2_sy;
  logic signed [ProdW-1:0] f2_p1, f2_p2, f2_q1, f2_q2, f2_q3, f2_q4;
  logic [StW-1:0]          f2_st;

  // stage 3: cross product and squared lengths
  logic signed [CrossW-1:0] cross_c;
  logic signed [CoordW-1:0] f3_ax, f3_ay;
  logic signed [DiffW-1:0] f3_bxr, f3_byr, f3_cxr, f3_cyr;
  logic signed [SumW-1:0]  f3_sbc, f3_sby, f3_sx, f3_sy;
  logic signed [SqW-1:0]   f3_bb, f3_cc;
  logic signed [DW-1:0]    f3_d;
  logic [StW-1:0]          f3_st;

  // stage 4: products with squared lengths and with d
  logic signed [TW-1:0]    f4_t1, f4_t2, f4_t3, f4_t4;
  logic signed [DaW-1:0]   f4_dax, f4_day;
  logic signed [DsumW-1:0] f4_dsb, f4_dsy;
  logic signed [DW-1:0]    f4_d;
  logic signed [SumW-1:0]  f4_sx, f4_sy;
  logic [StW-1:0]          f4_st;

  // stage 5: bisector numerators
  logic signed [NumW-1:0]  f5_numx, f5_numy;
  logic signed [DaW-1:0]   f5_dax, f5_day;
  logic signed [DsumW-1:0] f5_dsb, f5_dsy;
  logic signed [DW-1:0]    f5_d;
  logic signed [SumW-1:0]  f5_sx, f5_sy;
  logic [StW-1:0]          f5_st;

  // stage 6: circumcenter numerators and Euler direction
  mid_t f6;

  assign bxr_c = DiffW'(in_tri.bx) - DiffW'(in_tri.ax);
  assign byr_c = DiffW'(in_tri.by_coord) - DiffW'(in_tri.ay);
  assign cxr_c = DiffW'(in_tri.cx) - DiffW'(in_tri.ax);
  assign cyr_c = DiffW'(in_tri.cy) - DiffW'(in_tri.ay);
  assign cross_c = CrossW'(f2_p1) - CrossW'(f2_p2);

  assign out_valid = vld[5];
  assign out_mid   = f6;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_ax  <= in_tri.ax;
      f1_ay  <= in_tri.ay;
      f1_bxr <= bxr_c;
      f1_byr <= byr_c;
      f1_cxr <= cxr_c;
      f1_cyr <= cyr_c;
      f1_sbc <= SumW'(bxr_c) + SumW'(cxr_c);
      f1_sby <= SumW'(byr_c) + SumW'(cyr_c);
      f1_sx  <= SumW'(in_tri.ax) + SumW'(in_tri.bx) + SumW'(in_tri.cx);
      f1_sy  <= SumW'(in_tri.ay) + SumW'(in_tri.by_coord) + SumW'(in_tri.cy);
      if (in_tri.bx == in_tri.ax || in_tri.cx == in_tri.ax || in_tri.cx == in_tri.bx) begin
        f1_st <= ST_VERT_SIDE;
      end else if (in_tri.by_coord == in_tri.ay || in_tri.cy == in_tri.ay ||
                   in_tri.cy == in_tri.by_coord) begin
        f1_st <= ST_HORZ_SIDE;
      end else begin
        f1_st <= ST_OK;
      end

      f2_ax  <= f1_ax;
      f2_ay  <= f1_ay;
      f2_bxr <= f1_bxr;
      f2_byr <= f1_byr;
      f2_cxr <= f1_cxr;
      f2_cyr <= f1_cyr;
      f2_sbc <= f1_sbc;
      f2_sby <= f1_sby;
      f2_sx  <= f1_sx;
      f2_sy  <= f1_sy;
      f2_st  <= f1_st;
      f2_p1  <= ProdW'(f1_bxr) * ProdW'(f1_cyr);
      f2_p2  <= ProdW'(f1_byr) * ProdW'(f1_cxr);
      f2_q1  <= ProdW'(f1_bxr) * ProdW'(f1_bxr);
      f2_q2  <= ProdW'(f1_byr) * ProdW'(f1_byr);
      f2_q3  <= ProdW'(f1_cxr) * ProdW'(f1_cxr);
      f2_q4  <= ProdW'(f1_cyr) * ProdW'(f1_cyr);

      f3_ax  <= f2_ax;
      f3_ay  <= f2_ay;
      f3_bxr <= f2_bxr;
      f3_byr <= f2_byr;
      f3_cxr <= f2_cxr;
      f3_cyr <= f2_cyr;
      f3_sbc <= f2_sbc;
      f3_sby <= f2_sby;
      f3_sx  <= f2_sx;
      f3_sy  <= f2_sy;
      f3_bb  <= SqW'(f2_q1) + SqW'(f2_q2);
      f3_cc  <= SqW'(f2_q3) + SqW'(f2_q4);
      f3_d   <= {cross_c, 1'b0};
      // collinear vertices leave the bisectors parallel
      f3_st  <= (f2_st == ST_OK && f2_p1 == f2_p2) ? ST_PARALLEL : f2_st;

      f4_t1  <= TW'(f3_cyr) * TW'(f3_bb);
      f4_t2  <= TW'(f3_byr) * TW'(f3_cc);
      f4_t3  <= TW'(f3_bxr) * TW'(f3_cc);
      f4_t4  <= TW'(f3_cxr) * TW'(f3_bb);
      f4_dax <= DaW'(f3_d) * DaW'(f3_ax);
      f4_day <= DaW'(f3_d) * DaW'(f3_ay);
      f4_dsb <= DsumW'(f3_d) * DsumW'(f3_sbc);
      f4_dsy <= DsumW'(f3_d) * DsumW'(f3_sby);
      f4_d   <= f3_d;
      f4_sx  <= f3_sx;
      f4_sy  <= f3_sy;
      f4_st  <= f3_st;

      f5_numx <= NumW'(f4_t1) - NumW'(f4_t2);
      f5_numy <= NumW'(f4_t3) - NumW'(f4_t4);
      f5_dax  <= f4_dax;
      f5_day  <= f4_day;
      f5_dsb  <= f4_dsb;
      f5_dsy  <= f4_dsy;
      f5_d    <= f4_d;
      f5_sx   <= f4_sx;
      f5_sy   <= f4_sy;
      f5_st   <= f4_st;

      f6.st  <= f5_st;
      f6.sx  <= f5_sx;
      f6.sy  <= f5_sy;
      f6.d   <= f5_d;
      f6.cnx <= CnW'(f5_dax) + CnW'(f5_numx);
      f6.cny <= CnW'(f5_day) + CnW'(f5_numy);
      // centroid minus circumcenter, both scaled by 3d
      f6.ds  <= DsW'(f5_dsb) - (DsW'(f5_numx) <<< 1) - DsW'(f5_numx);
      f6.ns  <= DsW'(f5_dsy) - (DsW'(f5_numy) <<< 1) - DsW'(f5_numy);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tel_div.sv */
`default_nettype none

module tel_div #(
  parameter int NW = 18,
  parameter int DW = 3
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [NW-1:0] num,
  input  wire logic signed [DW-1:0] den,
  output logic [tel_pkg::OutW-1:0]  quo
);

  import tel_pkg::*;

  localparam int QB = OutW;
  localparam int MW = NW + FracBits + 2;
  localparam int RW = DW + 2;
  localparam int HW = MW - QB;
  localparam int CW = (HW > RW) ? HW : RW;

  logic [NW-1:0] mn;
  logic [DW-1:0] md;
  logic [MW-1:0] nm;
  logic [RW-1:0] d2;
  logic [HW-1:0] hi;

  logic [RW-1:0] rem [0:QB];
  logic [QB-1:0] lo  [0:QB];
  logic [QB-1:0] q   [0:QB];
  logic [RW-1:0] dd  [0:QB];
  logic [QB:0]   neg;
  logic [QB:0]   ovf;

  logic [RW-1:0] t     [0:QB-1];
  logic [QB-1:0] ge;

  logic [QB-1:0] sat;

  // magnitudes; rounding adds half the divisor before the quotient
  assign mn = num[NW-1] ? NW'(-num) : NW'(num);
  assign md = den[DW-1] ? DW'(-den) : DW'(den);
  assign nm = (MW'(mn) << (FracBits + 1)) + MW'(md);
  assign d2 = RW'(md) << 1;
  assign hi = nm[MW-1:QB];

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      t[k]  = {rem[k][RW-2:0], lo[k][QB-1]};
      ge[k] = (t[k] >= dd[k]);
    end
  end

  always_comb begin
    if (!neg[QB]) begin
      sat = (ovf[QB] || q[QB][QB-1]) ? {1'b0, {(QB-1){1'b1}}} : q[QB];
    end else if (ovf[QB] || q[QB] > {1'b1, {(QB-1){1'b0}}}) begin
      sat = {1'b1, {(QB-1){1'b0}}};
    end else begin
      sat = -q[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= RW'(hi);
      lo[0]  <= nm[QB-1:0];
      q[0]   <= '0;
      dd[0]  <= d2;
      neg[0] <= num[NW-1] ^ den[DW-1];
      ovf[0] <= (CW'(hi) >= CW'(d2));
      for (int k = 0; k < QB; k++) begin
        rem[k+1] <= ge[k] ? t[k] - dd[k] : t[k];
        lo[k+1]  <= lo[k] << 1;
        q[k+1]   <= {q[k][QB-2:0], ge[k]};
        dd[k+1]  <= dd[k];
        neg[k+1] <= neg[k];
        ovf[k+1] <= ovf[k];
      end
      quo <= sat;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tel_back.sv */
`default_nettype none

module tel_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic [tel_pkg::SpanW-1:0]  span,
  input  wire logic                       in_valid,
  input  wire tel_pkg::mid_t              in_mid,
  output logic                            out_valid,
  output tel_pkg::res_t                   out_res
);

  import tel_pkg::*;

  // centroid: magnitude of the vertex sum divided by 3 through a reciprocal
  localparam int MagW   = SumW - 1;
  localparam int RecipW = SumW - 1;
  localparam int ProdRW = MagW + RecipW;
  localparam int QuoW   = SumW - 2;
  localparam logic [RecipW-1:0]   Recip3 = RecipW'(((1 << SumW) + 2) / 3);
  localparam logic [FracBits-1:0] Third1 = FracBits'(((1 << FracBits) + 1) / 3);
  localparam logic [FracBits-1:0] Third2 = FracBits'(((2 << FracBits) + 1) / 3);

  logic signed [SpanMulW-1:0] span3;

  logic                     b1_vld;
  logic signed [BpW-1:0]    b1_p1, b1_p2;
  logic signed [StepW-1:0]  b1_step;
  logic signed [Den3W-1:0]  b1_den3;
  logic signed [DsW-1:0]    b1_ds, b1_ns;
  logic signed [CnW-1:0]    b1_cnx, b1_cny;
  logic signed [DW-1:0]     b1_d;
  logic signed [SumW-1:0]   b1_sx, b1_sy;
  logic [StW-1:0]           b1_st;

  logic                     b2_vld;
  logic signed [BaseW-1:0]  b2_base;
  logic signed [EndW-1:0]   b2_left, b2_right;
  logic signed [Den3W-1:0]  b2_den3;
  logic signed [DsW-1:0]    b2_ds, b2_ns;
  logic signed [CnW-1:0]    b2_cnx, b2_cny;
  logic signed [DW-1:0]     b2_d;
  logic signed [SumW-1:0]   b2_sx, b2_sy;
  logic [StW-1:0]           b2_st;

  logic [DivLat-1:0]        dv;
  logic [StW-1:0]           dst [0:DivLat-1];

  logic [MagW-1:0]          gm_x, gm_y;
  logic [MagW-1:0]          g1_mx, g1_my;
  logic [ProdRW-1:0]        g1_px, g1_py;
  logic                     g1_nx, g1_ny;
  logic [OutW-1:0]          gx_d [0:DivLat-2];
  logic [OutW-1:0]          gy_d [0:DivLat-2];

  logic [OutW-1:0] q_gx, q_gy, q_cx, q_cy, q_sl, q_ic, q_ly, q_ry;
  logic [StW-1:0]  st_o;
  logic            circ_ok, line_ok;

  // round m/3 to Q.FracBits; the remainder picks the rounded third
  function automatic logic [OutW-1:0] third_q(logic [MagW-1:0] m, logic [ProdRW-1:0] p,
                                              logic neg);
    logic [QuoW-1:0]     a;
    logic [1:0]          r;
    logic [FracBits-1:0] fr;
    logic [OutW-1:0]     q;
    a = p[ProdRW-1:SumW];
    r = 2'(m - MagW'(a) - (MagW'(a) << 1));
    case (r)
      2'd0: fr = '0;
      2'd1: fr = Third1;
      default: fr = Third2;
    endcase
    q = OutW'({a, fr});
    return neg ? -q : q;
  endfunction

  assign span3 = SpanMulW'(span) + (SpanMulW'(span) << 1);

  assign gm_x = b2_sx[SumW-1] ? MagW'(-b2_sx) : MagW'(b2_sx);
  assign gm_y = b2_sy[SumW-1] ? MagW'(-b2_sy) : MagW'(b2_sy);

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_vld <= 1'b0;
      b2_vld <= 1'b0;
      dv     <= '0;
    end else if (en) begin
      b1_vld <= in_valid;
      b2_vld <= b1_vld;
      dv     <= {dv[DivLat-2:0], b2_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_p1   <= BpW'(in_mid.ds) * BpW'(in_mid.sy);
      b1_p2   <= BpW'(in_mid.ns) * BpW'(in_mid.sx);
      b1_step <= StepW'(in_mid.ns) * StepW'(span3);
      b1_den3 <= Den3W'(in_mid.ds) + (Den3W'(in_mid.ds) <<< 1);
      b1_ds   <= in_mid.ds;
      b1_ns   <= in_mid.ns;
      b1_cnx  <= in_mid.cnx;
      b1_cny  <= in_mid.cny;
      b1_d    <= in_mid.d;
      b1_sx   <= in_mid.sx;
      b1_sy   <= in_mid.sy;
      // centroid and circumcenter on one vertical
      b1_st   <= (in_mid.st == ST_OK && in_mid.ds == '0) ? ST_VERT_EULER : in_mid.st;

      b2_base  <= BaseW'(b1_p1) - BaseW'(b1_p2);
      b2_left  <= EndW'(b1_p1) - EndW'(b1_p2) - EndW'(b1_step);
      b2_right <= EndW'(b1_p1) - EndW'(b1_p2) + EndW'(b1_step);
      b2_den3  <= b1_den3;
      b2_ds    <= b1_ds;
      b2_ns    <= b1_ns;
      b2_cnx   <= b1_cnx;
      b2_cny   <= b1_cny;
      b2_d     <= b1_d;
      b2_sx    <= b1_sx;
      b2_sy    <= b1_sy;
      b2_st    <= b1_st;

      dst[0] <= b2_st;
      for (int k = 1; k < DivLat; k++) begin
        dst[k] <= dst[k-1];
      end

      g1_mx <= gm_x;
      g1_my <= gm_y;
      g1_px <= ProdRW'(gm_x) * ProdRW'(Recip3);
      g1_py <= ProdRW'(gm_y) * ProdRW'(Recip3);
      g1_nx <= b2_sx[SumW-1];
      g1_ny <= b2_sy[SumW-1];

      // align the centroid with the divider outputs
      gx_d[0] <= third_q(g1_mx, g1_px, g1_nx);
      gy_d[0] <= third_q(g1_my, g1_py, g1_ny);
      for (int k = 1; k < DivLat - 1; k++) begin
        gx_d[k] <= gx_d[k-1];
        gy_d[k] <= gy_d[k-1];
      end
    end
  end

  assign q_gx = gx_d[DivLat-2];
  assign q_gy = gy_d[DivLat-2];

  tel_div #(.NW(CnW), .DW(DW)) u_div_cx (
    .clk(clk), .en(en), .num(b2_cnx), .den(b2_d), .quo(q_cx)
  );
  tel_div #(.NW(CnW), .DW(DW)) u_div_cy (
    .clk(clk), .en(en), .num(b2_cny), .den(b2_d), .quo(q_cy)
  );
  tel_div #(.NW(DsW), .DW(DsW)) u_div_sl (
    .clk(clk), .en(en), .num(b2_ns), .den(b2_ds), .quo(q_sl)
  );
  tel_div #(.NW(BaseW), .DW(Den3W)) u_div_ic (
    .clk(clk), .en(en), .num(b2_base), .den(b2_den3), .quo(q_ic)
  );
  tel_div #(.NW(EndW), .DW(Den3W)) u_div_ly (
    .clk(clk), .en(en), .num(b2_left), .den(b2_den3), .quo(q_ly)
  );
  tel_div #(.NW(EndW), .DW(Den3W)) u_div_ry (
    .clk(clk), .en(en), .num(b2_right), .den(b2_den3), .quo(q_ry)
  );

  assign st_o    = dst[DivLat-1];
  assign circ_ok = (st_o == ST_OK) || (st_o == ST_VERT_EULER);
  assign line_ok = (st_o == ST_OK);

  assign out_valid = dv[DivLat-1];

  always_comb begin
    out_res.status          = st_o;
    out_res.centroid_x      = q_gx;
    out_res.centroid_y      = q_gy;
    out_res.circum_x        = circ_ok ? q_cx : '0;
    out_res.circum_y        = circ_ok ? q_cy : '0;
    out_res.euler_slope     = line_ok ? q_sl : '0;
    out_res.euler_intercept = line_ok ? q_ic : '0;
    out_res.left_y          = line_ok ? q_ly : '0;
    out_res.right_y         = line_ok ? q_ry : '0;
  end

endmodule

`default_nettype wire

/* hw/rtl/triangle_euler_line.sv */
// From input item accept to the result on m_tvalid: 6 front stages, item queue,
//   2 back stages, 34-stage restoring dividers, output queue.
// Throughput: one triangle per cycle while no queue is full (pipelined dividers).
// Front and back stall independently across a 4-entry item queue.
// Reset (rst, synchronous): queues and pipeline valids cleared, line_span = 30.
`default_nettype none

module triangle_euler_line #(
  parameter int MID_DEPTH = tel_pkg::MidDepth,
  parameter int OUT_DEPTH = tel_pkg::OutDepth
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // ax, ay, bx, by_coord, cx, cy (16 bits each)
  input  wire logic [95:0]                 s_tdata,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // centroid_x, centroid_y, circum_x, circum_y, euler_slope,
  // euler_intercept, left_y, right_y (32 bits each)
  output logic [255:0]                     m_tdata,
  // status
  output logic [tel_pkg::StW-1:0]          m_tuser,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [tel_pkg::SpanW-1:0]   cfg_data
);

  import tel_pkg::*;

  logic [SpanW-1:0] line_span;

  logic  front_en, front_vld;
  mid_t  front_mid;
  logic  mid_full, mid_vld, mid_pop;
  mid_t  mid_head;
  logic [$bits(mid_t)-1:0] mid_raw;

  logic  back_en, back_vld;
  res_t  back_res;
  logic  out_full;
  logic [$bits(res_t)-1:0] out_raw;
  res_t  out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_span <= SpanReset;
    end else if (cfg_valid) begin
      line_span <= cfg_data;
    end
  end

  assign front_en = !mid_full;
  assign s_tready = front_en;

  tel_front u_front (
    .clk(clk), .rst(rst), .en(front_en),
    .in_valid(s_tvalid), .in_tri(tri_t'(s_tdata)),
    .out_valid(front_vld), .out_mid(front_mid)
  );

  tel_queue #(.WIDTH($bits(mid_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk(clk), .rst(rst),
    .push(front_en && front_vld), .wdata(front_mid),
    .pop(mid_pop), .rdata(mid_raw),
    .not_empty(mid_vld), .full(mid_full)
  );

  assign mid_head = mid_t'(mid_raw);
  assign back_en  = !out_full;
  assign mid_pop  = back_en && mid_vld;

  tel_back u_back (
    .clk(clk), .rst(rst), .en(back_en), .span(line_span),
    .in_valid(mid_vld), .in_mid(mid_head),
    .out_valid(back_vld), .out_res(back_res)
  );

  tel_queue #(.WIDTH($bits(res_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk(clk), .rst(rst),
    .push(back_en && back_vld), .wdata(back_res),
    .pop(m_tvalid && m_tready), .rdata(out_raw),
    .not_empty(m_tvalid), .full(out_full)
  );

  assign out_res = res_t'(out_raw);
  assign m_tdata = out_res[255:0];
  assign m_tuser = out_res.status;

endmodule

`default_nettype wire

/* hw/rtl/tel_checker.sv */
`default_nettype none

module tel_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [255:0] m_tdata,
  input wire logic [2:0]   m_tuser
);

  import tel_pkg::*;

  // degenerate triangles carry no circumcenter and no line
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_VERT_SIDE || m_tuser == ST_HORZ_SIDE ||
                 m_tuser == ST_PARALLEL) |-> m_tdata[255:64] == '0)
    else $error("circumcenter or line fields set on degenerate triangle");

  // vertical Euler line carries no slope, intercept or end heights
  a_vertical_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_VERT_EULER |-> m_tdata[255:128] == '0)
    else $error("line fields set on vertical Euler line");

  // centroid lies inside the coordinate range, so it never hits positive saturation
  a_centroid_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:0] != 32'h7FFF_FFFF) && (m_tdata[63:32] != 32'h7FFF_FFFF))
    else $error("centroid saturated");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind triangle_euler_line tel_checker u_tel_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser)
);

`default_nettype wire

/* bench/triangle_euler_line_test.sv */
`timescale 1ns / 100ps

module triangle_euler_line_test;
  import tel_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int Settle     = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [95:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [255:0] m_tdata;
  logic [StW-1:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SpanW-1:0] cfg_data = '0;

  triangle_euler_line i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  logic [95:0] tri_pending[$];
  res_t        euler_due[$];
  logic [SpanW-1:0] span_now = SpanReset;
  int mismatches = 0;
  int cycles = 0;
  int hold_req = 0;

  // round n/d to Q16.16, ties away from zero, saturated
  function automatic logic [31:0] q16_div(logic signed [127:0] n, logic signed [127:0] d);
    logic [127:0] mn, md, q, qn;
    logic neg;
    neg = n[127] ^ d[127];
    mn = n[127] ? -n : n;
    md = d[127] ? -d : d;
    q = ((mn << (FracBits + 1)) + md) / (md << 1);
    if (!neg) begin
      if (q > 128'h7fffffff) q = 128'h7fffffff;
      return q[31:0];
    end
    if (q > 128'h80000000) q = 128'h80000000;
    qn = -q;
    return qn[31:0];
  endfunction

  function automatic res_t euler_predict(logic [95:0] t, logic [SpanW-1:0] span);
    tri_t v;
    res_t r;
    logic signed [127:0] ax, ay, bx, by, cx, cy, bxr, byr, cxr, cyr, sx, sy, crs;
    logic signed [127:0] d, bb, cc, numx, numy, ds, ns, base, den3, stp, sp;
    v = t;
    ax = 128'(v.ax); ay = 128'(v.ay); bx = 128'(v.bx);
    by = 128'(v.by_coord); cx = 128'(v.cx); cy = 128'(v.cy);
    sp = 128'(span);
    bxr = bx - ax; byr = by - ay; cxr = cx - ax; cyr = cy - ay;
    sx = ax + bx + cx; sy = ay + by + cy;
    crs = bxr * cyr - byr * cxr;
    r = '0;
    r.centroid_x = q16_div(sx, 128'sd3);
    r.centroid_y = q16_div(sy, 128'sd3);
    if (bx == ax || cx == ax || cx == bx) r.status = ST_VERT_SIDE;
    else if (by == ay || cy == ay || cy == by) r.status = ST_HORZ_SIDE;
    else if (crs == 0) r.status = ST_PARALLEL;
    else begin
      r.status = ST_OK;
      d = 2 * crs;
      bb = bxr * bxr + byr * byr;
      cc = cxr * cxr + cyr * cyr;
      numx = cyr * bb - byr * cc;
      numy = bxr * cc - cxr * bb;
      r.circum_x = q16_div(d * ax + numx, d);
      r.circum_y = q16_div(d * ay + numy, d);
      // centroid minus circumcenter, both scaled by 3d
      ds = d * (bxr + cxr) - 3 * numx;
      ns = d * (byr + cyr) - 3 * numy;
      if (ds == 0) r.status = ST_VERT_EULER;
      else begin
        base = ds * sy - ns * sx;
        den3 = 3 * ds;
        stp = ns * 3 * sp;
        r.euler_slope = q16_div(ns, ds);
        r.euler_intercept = q16_div(base, den3);
        r.left_y = q16_div(base - stp, den3);
        r.right_y = q16_div(base + stp, den3);
      end
    end
    return r;
  endfunction

  // sender: bursts of random length with random gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) euler_due.push_back(euler_predict(s_tdata, span_now));
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (tri_pending.size() > 0) begin
          s_tdata <= tri_pending.pop_front();
          s_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: own stall pattern, plus long hold-offs on request
  int hold_seen = 0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_count = 0;
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_seen + 1;
      hold_left <= 400;
      m_tready <= 1'b0;
    end else begin
      rx_count <= rx_count + 1;
      if (rx_count % 64 == 63) rx_mode <= $urandom_range(0, 3);
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 9) < 7);
        2: m_tready <= rx_count[0];
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // compare each result with the oldest prediction
  always @(posedge clk) begin
    res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata};
      if (euler_due.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %h", got);
      end else begin
        want = euler_due.pop_front();
        if (got.centroid_x !== want.centroid_x || got.centroid_y !== want.centroid_y ||
            got.circum_x !== want.circum_x || got.circum_y !== want.circum_y ||
            got.euler_slope !== want.euler_slope ||
            got.euler_intercept !== want.euler_intercept ||
            got.left_y !== want.left_y || got.right_y !== want.right_y ||
            got.status !== want.status) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("mismatch: expected cen %h %h circ %h %h line %h %h ends %h %h st %0d",
              want.centroid_x, want.centroid_y, want.circum_x, want.circum_y,
              want.euler_slope, want.euler_intercept, want.left_y, want.right_y, want.status);
            $display("  actual cen %h %h circ %h %h line %h %h ends %h %h st %0d",
              got.centroid_x, got.centroid_y, got.circum_x, got.circum_y,
              got.euler_slope, got.euler_intercept, got.left_y, got.right_y, got.status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [15:0] rand_coord(int spread);
    case (spread)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 16)) - 16'd8;
      default: return 16'($urandom_range(0, 2000)) - 16'd1000;
    endcase
  endfunction

  task automatic add_tri(int ax, int ay, int bx, int by, int cx, int cy);
    tri_pending.push_back({16'(cy), 16'(cx), 16'(by), 16'(bx), 16'(ay), 16'(ax)});
  endtask

  task automatic add_random(int n);
    int spread;
    for (int i = 0; i < n; i++) begin
      spread = $urandom_range(0, 2);
      tri_pending.push_back({rand_coord(spread), rand_coord(spread), rand_coord(spread),
                             rand_coord(spread), rand_coord(spread), rand_coord(spread)});
    end
  endtask

  // wait for the pipe to drain, then let the latency pass
  task automatic drain;
    do @(negedge clk);
    while (tri_pending.size() > 0 || euler_due.size() > 0 || s_tvalid);
    repeat (Settle) @(negedge clk);
  endtask

  task automatic write_span(logic [SpanW-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    span_now = v;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    add_tri(0, 0, 4, 3, -2, 7);
    add_tri(1, 1, 1, 5, 3, 2);                  // vertical side
    add_tri(2, 2, 2, 2, 2, 2);                  // equal vertices
    add_tri(1, 1, 5, 1, 3, 4);                  // horizontal side
    add_tri(0, 0, 1, 2, 2, 4);                  // collinear
    add_tri(7, 4, -8, 1, 1, -8);                // vertical Euler line
    add_tri(0, 0, 30000, 1, -30000, -2);        // saturating circumcenter
    add_tri(-32768, -32767, 32767, -32768, -32767, 32767);
    add_tri(32767, 32767, -32768, 0, 0, -32768);
    add_tri(-32768, -32768, 32767, 32766, 32766, 32767);
    add_tri(-1, 1, 1, -1, 0, 2);
    add_tri(32767, -32768, -32768, 32767, 1, 0);
    drain();

    write_span(SpanW'(1));
    add_tri(0, 0, 4, 3, -2, 7);
    add_tri(-32768, -32767, 32767, -32768, -32767, 32767);
    add_random(100);
    drain();

    write_span(SpanW'(32767));
    add_tri(0, 0, 4, 3, -2, 7);
    add_tri(0, 0, 30000, 1, -30000, -2);
    add_random(100);
    // hold the output long enough for the input to back up
    hold_req = hold_req + 1;
    drain();

    write_span(SpanW'($urandom_range(1, 32767)));
    add_random(100);
    drain();

    write_span(SpanW'($urandom_range(2, 32766)));
    add_random(100);
    hold_req = hold_req + 1;
    drain();

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* triangle_euler_line.f */
hw/rtl/tel_pkg.sv
hw/rtl/tel_queue.sv
hw/rtl/tel_front.sv
hw/rtl/tel_div.sv
hw/rtl/tel_back.sv
hw/rtl/triangle_euler_line.sv
hw/rtl/tel_checker.sv
bench/triangle_euler_line_test.sv
